// ===== rtl/checksummed_frame_receiver_top_macros.svh =====
// Assertion macros for the checksummed frame receiver
`ifndef CHECKSUMMED_FRAME_RECEIVER_TOP_MACROS_SVH
`define CHECKSUMMED_FRAME_RECEIVER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define CFR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define CFR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/cfr_pkg.sv =====
// Shared types and constants for the checksummed frame receiver
package cfr_pkg;

	localparam logic [7:0] HEADER_BYTE       = 8'hAB;
	localparam logic [7:0] MAX_PAYLOAD_RESET = 8'd10;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_SRC,
		PH_DST,
		PH_FUNC,
		PH_LEN,
		PH_PAYLOAD,
		PH_SUMCHK,
		PH_ADDCHK
	} phase_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_GOOD    = 2'd1,
		KIND_BAD     = 2'd2
	} kind_t;

endpackage

// ===== rtl/cfr_ifs.sv =====
// Channel interfaces: received bytes, results, configuration writes
interface cfr_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface cfr_res_if;
	import cfr_pkg::*;
	logic       valid;
	logic       ready;
	kind_t      kind;
	logic [7:0] payload_byte;
	logic [7:0] payload_index;
	logic [7:0] source_address;
	logic [7:0] target_address;
	logic [7:0] function_code;
	logic [7:0] frame_length;
	modport source (output valid, output kind, output payload_byte, output payload_index,
		output source_address, output target_address, output function_code,
		output frame_length, input ready);
	modport sink (input valid, input kind, input payload_byte, input payload_index,
		input source_address, input target_address, input function_code,
		input frame_length, output ready);
endinterface

interface cfr_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] max_payload;
	modport source (output valid, output max_payload, input ready);
	modport sink (input valid, input max_payload, output ready);
endinterface

// ===== rtl/checksummed_frame_receiver_top.sv =====
// Checksummed frame receiver: parses header, payload and two check bytes
// A result is registered and appears on res in the cycle after the byte that causes it is taken.
// Throughput: one byte per cycle; a byte is taken whenever the result
// register is empty or its transaction completes in the same cycle.
// Reset (arst_n low, asynchronous): hunting for header, max_payload = 10,
// no result pending.
`include "checksummed_frame_receiver_top_macros.svh"

module checksummed_frame_receiver_top (
	input logic      clk,
	input logic      arst_n,
	cfr_rx_if.sink   rx,
	cfr_res_if.source res,
	cfr_cfg_if.sink  cfg
);
	import cfr_pkg::*;

	phase_t     phase_q, phase_d;
	logic [7:0] src_q, src_d;
	logic [7:0] dst_q, dst_d;
	logic [7:0] func_q, func_d;
	logic [7:0] len_q, len_d;
	logic [7:0] cnt_q, cnt_d;
	logic [7:0] sum_q, sum_d;
	logic [7:0] add_q, add_d;
	logic       match_q, match_d;
	logic [7:0] max_q;

	logic       emit_d;
	kind_t      kind_d;
	logic [7:0] pbyte_d;
	logic [7:0] pindex_d;

	logic       res_valid_q;
	kind_t      kind_q;
	logic [7:0] pbyte_q, pindex_q, osrc_q, odst_q, ofunc_q, olen_q;

	logic       rx_fire;
	logic [7:0] b;

	assign b         = rx.rx_byte;
	assign rx.ready  = !res_valid_q || res.ready;
	assign rx_fire   = rx.valid && rx.ready;
	assign cfg.ready = 1'b1;

	// next state
	always_comb begin
		phase_d = phase_q;
		src_d   = src_q;
		dst_d   = dst_q;
		func_d  = func_q;
		len_d   = len_q;
		cnt_d   = cnt_q;
		sum_d   = sum_q + b;
		add_d   = add_q + sum_d;
		match_d = match_q;
		case (phase_q)
			PH_HUNT: begin
				sum_d = sum_q;
				add_d = add_q;
				if (b == HEADER_BYTE) begin
					sum_d   = b;
					add_d   = b;
					cnt_d   = 8'd0;
					len_d   = 8'd0;
					phase_d = PH_SRC;
				end
			end
			PH_SRC: begin
				src_d   = b;
				phase_d = PH_DST;
			end
			PH_DST: begin
				dst_d   = b;
				phase_d = PH_FUNC;
			end
			PH_FUNC: begin
				func_d  = b;
				cnt_d   = 8'd0;
				phase_d = PH_LEN;
			end
			PH_LEN: begin
				if (cnt_q == 8'd0) begin
					len_d = b;
					cnt_d = 8'd1;
				end else begin
					cnt_d = 8'd0;
					if ({b, len_q} > {8'd0, max_q})
						phase_d = PH_HUNT;
					else if (b == 8'd0 && len_q == 8'd0)
						phase_d = PH_SUMCHK;
					else
						phase_d = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				cnt_d = cnt_q + 8'd1;
				if ({1'b0, cnt_q} + 9'd1 >= {1'b0, len_q})
					phase_d = PH_SUMCHK;
			end
			PH_SUMCHK: begin
				sum_d   = sum_q;
				add_d   = add_q;
				match_d = (b == sum_q);
				phase_d = PH_ADDCHK;
			end
			PH_ADDCHK: begin
				sum_d   = sum_q;
				add_d   = add_q;
				phase_d = PH_HUNT;
			end
			default: begin
				sum_d   = sum_q;
				add_d   = add_q;
				phase_d = PH_HUNT;
			end
		endcase
	end

	// result of the current byte
	always_comb begin
		emit_d   = 1'b0;
		kind_d   = KIND_PAYLOAD;
		pbyte_d  = 8'd0;
		pindex_d = 8'd0;
		case (phase_q)
			PH_PAYLOAD: begin
				emit_d   = 1'b1;
				pbyte_d  = b;
				pindex_d = cnt_q;
			end
			PH_ADDCHK: begin
				emit_d = 1'b1;
				kind_d = (match_q && b == add_q) ? KIND_GOOD : KIND_BAD;
			end
			default: begin
				emit_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			src_q   <= 8'd0;
			dst_q   <= 8'd0;
			func_q  <= 8'd0;
			len_q   <= 8'd0;
			cnt_q   <= 8'd0;
			sum_q   <= 8'd0;
			add_q   <= 8'd0;
			match_q <= 1'b0;
		end else if (rx_fire) begin
			phase_q <= phase_d;
			src_q   <= src_d;
			dst_q   <= dst_d;
			func_q  <= func_d;
			len_q   <= len_d;
			cnt_q   <= cnt_d;
			sum_q   <= sum_d;
			add_q   <= add_d;
			match_q <= match_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_PAYLOAD_RESET;
		end else if (cfg.valid) begin
			max_q <= cfg.max_payload;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (rx_fire) begin
			res_valid_q <= emit_d;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_fire && emit_d) begin
			kind_q   <= kind_d;
			pbyte_q  <= pbyte_d;
			pindex_q <= pindex_d;
			osrc_q   <= src_q;
			odst_q   <= dst_q;
			ofunc_q  <= func_q;
			olen_q   <= len_q;
		end
	end

	assign res.valid          = res_valid_q;
	assign res.kind           = kind_q;
	assign res.payload_byte   = pbyte_q;
	assign res.payload_index  = pindex_q;
	assign res.source_address = osrc_q;
	assign res.target_address = odst_q;
	assign res.function_code  = ofunc_q;
	assign res.frame_length   = olen_q;

	`CFR_ASSERT_NOW(a_payload_idx, phase_q == PH_PAYLOAD, cnt_q < len_q && len_q != 8'd0, "payload count past frame length")
	`CFR_ASSERT_NOW(a_verdict_zero, res_valid_q && kind_q != KIND_PAYLOAD, pbyte_q == 8'd0 && pindex_q == 8'd0, "verdict carries payload data")
	`CFR_ASSERT_NOW(a_index_range, res_valid_q && kind_q == KIND_PAYLOAD, pindex_q < olen_q, "payload index beyond frame length")
	`CFR_ASSERT_NEXT(a_verdict_out, rx_fire && phase_q == PH_ADDCHK, res_valid_q && kind_q != KIND_PAYLOAD && phase_q == PH_HUNT, "missing verdict after add check byte")

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the checksummed frame receiver with a frame-level scoreboard

typedef logic [7:0] byte_q_t[$];

typedef struct {
	cfr_pkg::kind_t kind;
	logic [7:0]     payload_byte;
	logic [7:0]     payload_index;
	logic [7:0]     source_address;
	logic [7:0]     target_address;
	logic [7:0]     function_code;
	logic [7:0]     frame_length;
} frame_result_t;

class frame_scoreboard;
	cfr_pkg::phase_t rx_phase;
	logic [7:0]      src_addr;
	logic [7:0]      dst_addr;
	logic [7:0]      func_id;
	logic [15:0]     length;
	logic [7:0]      count;
	logic [7:0]      run_sum;
	logic [7:0]      run_sum_of_sums;
	bit              sum_ok;
	logic [7:0]      max_payload;
	frame_result_t   pending[$];
	int              bytes_seen;
	int              results_checked;
	int              good_frames;
	int              bad_frames;
	int              errors;

	function new();
		rx_phase        = cfr_pkg::PH_HUNT;
		src_addr        = '0;
		dst_addr        = '0;
		func_id         = '0;
		length          = '0;
		count           = '0;
		run_sum         = '0;
		run_sum_of_sums = '0;
		sum_ok          = 1'b0;
		max_payload     = cfr_pkg::MAX_PAYLOAD_RESET;
	endfunction

	function void accumulate(logic [7:0] b);
		run_sum         = run_sum + b;
		run_sum_of_sums = run_sum_of_sums + run_sum;
	endfunction

	function void push_result(cfr_pkg::kind_t k, logic [7:0] value, logic [7:0] idx);
		frame_result_t r;
		r.kind           = k;
		r.payload_byte   = value;
		r.payload_index  = idx;
		r.source_address = src_addr;
		r.target_address = dst_addr;
		r.function_code  = func_id;
		r.frame_length   = length[7:0];
		pending.push_back(r);
	endfunction

	function void note_byte(logic [7:0] b);
		bytes_seen++;
		case (rx_phase)
			cfr_pkg::PH_HUNT: begin
				if (b == cfr_pkg::HEADER_BYTE) begin
					run_sum         = '0;
					run_sum_of_sums = '0;
					accumulate(b);
					count    = '0;
					length   = '0;
					rx_phase = cfr_pkg::PH_SRC;
				end
			end
			cfr_pkg::PH_SRC: begin
				src_addr = b;
				accumulate(b);
				rx_phase = cfr_pkg::PH_DST;
			end
			cfr_pkg::PH_DST: begin
				dst_addr = b;
				accumulate(b);
				rx_phase = cfr_pkg::PH_FUNC;
			end
			cfr_pkg::PH_FUNC: begin
				func_id = b;
				accumulate(b);
				count    = '0;
				rx_phase = cfr_pkg::PH_LEN;
			end
			cfr_pkg::PH_LEN: begin
				accumulate(b);
				if (count == 8'd0) begin
					length = {8'h00, b};
					count  = 8'd1;
				end else begin
					length = {b, length[7:0]};
					count  = 8'd0;
					if (length > {8'h00, max_payload})
						rx_phase = cfr_pkg::PH_HUNT;
					else if (length == 16'd0)
						rx_phase = cfr_pkg::PH_SUMCHK;
					else
						rx_phase = cfr_pkg::PH_PAYLOAD;
				end
			end
			cfr_pkg::PH_PAYLOAD: begin
				accumulate(b);
				push_result(cfr_pkg::KIND_PAYLOAD, b, count);
				count = count + 8'd1;
				if ({8'h00, count} >= length)
					rx_phase = cfr_pkg::PH_SUMCHK;
			end
			cfr_pkg::PH_SUMCHK: begin
				sum_ok   = (b == run_sum);
				rx_phase = cfr_pkg::PH_ADDCHK;
			end
			default: begin
				if (sum_ok && b == run_sum_of_sums)
					push_result(cfr_pkg::KIND_GOOD, 8'h00, 8'h00);
				else
					push_result(cfr_pkg::KIND_BAD, 8'h00, 8'h00);
				rx_phase = cfr_pkg::PH_HUNT;
			end
		endcase
	endfunction

	function void compare_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	function void check_result(frame_result_t got);
		frame_result_t want;
		if (pending.size() == 0) begin
			$error("unexpected result transaction, kind %0d", got.kind);
			errors++;
			return;
		end
		want = pending.pop_front();
		results_checked++;
		if (want.kind == cfr_pkg::KIND_GOOD)
			good_frames++;
		else if (want.kind == cfr_pkg::KIND_BAD)
			bad_frames++;
		compare_field("kind", 8'(want.kind), 8'(got.kind));
		compare_field("payload_byte", want.payload_byte, got.payload_byte);
		compare_field("payload_index", want.payload_index, got.payload_index);
		compare_field("source_address", want.source_address, got.source_address);
		compare_field("target_address", want.target_address, got.target_address);
		compare_field("function_code", want.function_code, got.function_code);
		compare_field("frame_length", want.frame_length, got.frame_length);
	endfunction
endclass

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import cfr_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 4;
	localparam int BYTES_PER_PHASE = 500;

	logic clk = 1'b0;
	logic arst_n;
	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;
	int   stall_cycles = 0;
	int   cfg_writes = 0;

	frame_scoreboard sb = new();

	cfr_rx_if  rx_ch();
	cfr_res_if res_ch();
	cfr_cfg_if cfg_ch();

	checksummed_frame_receiver_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		frame_result_t got;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got.kind           = res_ch.kind;
			got.payload_byte   = res_ch.payload_byte;
			got.payload_index  = res_ch.payload_index;
			got.source_address = res_ch.source_address;
			got.target_address = res_ch.target_address;
			got.function_code  = res_ch.function_code;
			got.frame_length   = res_ch.frame_length;
			sb.check_result(got);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$error("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
				$display("FAILURE");
				$finish;
			end
		end
	end

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(15))
			0: return 8'h00;
			1: return 8'hFF;
			2: return HEADER_BYTE;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic byte_q_t random_payload(int n);
		byte_q_t q;
		for (int i = 0; i < n; i++)
			q.push_back(rand_byte());
		return q;
	endfunction

	// called at a falling edge; leaves valid high, the caller lowers it when pausing
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			rx_ch.valid <= 1'b0;
			@(negedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		do
			@(posedge clk);
		while (!(rx_ch.valid && rx_ch.ready));
		sb.note_byte(b);
		@(negedge clk);
	endtask

	// corrupt bit 0 spoils the sum byte, bit 1 the sum-of-sums byte
	task automatic send_frame(input logic [7:0] src, input logic [7:0] dst,
			input logic [7:0] func, input logic [15:0] len, input byte_q_t payload,
			input int corrupt, input bit with_check);
		byte_q_t    bytes;
		logic [7:0] s;
		logic [7:0] a;
		bytes = {HEADER_BYTE, src, dst, func, len[7:0], len[15:8]};
		foreach (payload[i])
			bytes.push_back(payload[i]);
		s = '0;
		a = '0;
		foreach (bytes[i]) begin
			s = s + bytes[i];
			a = a + s;
		end
		if (with_check) begin
			bytes.push_back(corrupt[0] ? s ^ 8'($urandom_range(1, 255)) : s);
			bytes.push_back(corrupt[1] ? a ^ 8'($urandom_range(1, 255)) : a);
		end
		foreach (bytes[i])
			send_byte(bytes[i]);
	endtask

	task automatic drain_results();
		rx_ch.valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_max_payload(input logic [7:0] value);
		drain_results();
		cfg_ch.valid       <= 1'b1;
		cfg_ch.max_payload <= value;
		do
			@(posedge clk);
		while (!(cfg_ch.valid && cfg_ch.ready));
		sb.max_payload = value;
		cfg_writes++;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic random_traffic(input int n_bytes);
		int          stop;
		int          cap;
		int          r;
		bit          paused;
		logic [15:0] len;
		stop   = sb.bytes_seen + n_bytes;
		paused = 1'b0;
		while (sb.bytes_seen < stop) begin
			if (!paused && sb.bytes_seen > stop - n_bytes / 2) begin
				drain_results();
				paused = 1'b1;
			end
			cap = (sb.max_payload < 16) ? sb.max_payload : 16;
			r   = $urandom_range(99);
			if (r < 75) begin
				len = ($urandom_range(19) == 0) ? {8'h00, sb.max_payload} :
					16'($urandom_range(0, cap));
				send_frame(rand_byte(), rand_byte(), rand_byte(), len, random_payload(len),
					($urandom_range(4) == 0) ? $urandom_range(1, 3) : 0, 1'b1);
			end else if (r < 85) begin
				repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
			end else if (r < 93) begin
				if (sb.max_payload == 8'hFF || $urandom_range(1))
					len = {8'($urandom_range(1, 255)), 8'($urandom)};
				else
					len = {8'h00, 8'($urandom_range(sb.max_payload + 1, 255))};
				send_frame(rand_byte(), rand_byte(), rand_byte(), len,
					random_payload($urandom_range(0, 4)), 0, 1'b0);
			end else begin
				len = 16'($urandom_range(0, cap));
				send_frame(rand_byte(), rand_byte(), rand_byte(), len,
					random_payload((len == 0) ? 0 : $urandom_range(0, len - 1)), 0, 1'b0);
			end
		end
	endtask

	initial begin
		byte_q_t fixed;
		arst_n             = 1'b0;
		rx_ch.valid        = 1'b0;
		rx_ch.rx_byte      = '0;
		res_ch.ready       = 1'b0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.max_payload = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// noise while hunting, empty good frame, header value as payload with bad check,
		// length one above the reset limit
		send_byte(8'h00);
		send_byte(8'hFF);
		send_frame(8'h00, 8'hFF, 8'h00, 16'd0, random_payload(0), 0, 1'b1);
		fixed = {HEADER_BYTE};
		send_frame(8'hFF, 8'h00, 8'hFF, 16'd1, fixed, 2, 1'b1);
		send_frame(8'h12, 8'h34, 8'h56, 16'd11, random_payload(0), 0, 1'b0);

		write_max_payload(8'hFF);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		random_traffic(BYTES_PER_PHASE);

		write_max_payload(8'($urandom_range(1, 30)));
		send_idle_pct  = 66;
		recv_stall_pct = 0;
		random_traffic(BYTES_PER_PHASE);

		write_max_payload(8'h00);
		send_idle_pct  = 0;
		recv_stall_pct = 66;
		random_traffic(BYTES_PER_PHASE);

		write_max_payload(8'($urandom_range(31, 254)));
		send_idle_pct  = 29;
		recv_stall_pct = 29;
		random_traffic(BYTES_PER_PHASE);

		drain_results();
		$display("Sent %0d bytes; checked %0d results, %0d good and %0d failed-check frames.",
			sb.bytes_seen, sb.results_checked, sb.good_frames, sb.bad_frames);
		$display("Covered %0d max_payload writes (0 and 255 included) under four idle/stall mixes.",
			cfg_writes);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
